/* rtl/core/smq_pkg.sv */
// Shared types and fixed network constants for the Q15 2-3-2 MLP classifier.
// Used by every module under rtl/core. No dependencies.
`timescale 1ns / 1ps

package smq_pkg;

  localparam int INPUT_COUNT   = 2;
  localparam int HIDDEN_COUNT  = 3;
  localparam int OUTPUT_COUNT  = 2;
  localparam int FRACTION_BITS = 15;

  localparam int Q15_W   = 16;                     // feature / weight width
  localparam int ACT_W   = 15;                     // activation after ReLU and clamp
  localparam int ACT_MAX = (1 << ACT_W) - 1;
  localparam int CLASS_W = $clog2(OUTPUT_COUNT);

  typedef logic signed [Q15_W-1:0] q15_t;
  typedef logic [ACT_W-1:0]        act_t;
  typedef logic [CLASS_W-1:0]      class_t;

  // per-lane stage enables: product stage and accumulate stage
  typedef struct packed {
    logic mul_en;
    logic acc_en;
  } lane_ctl_t;

  localparam q15_t HID_W [HIDDEN_COUNT][INPUT_COUNT] = '{
    '{ 16'sd16384, -16'sd16384},
    '{-16'sd16384,  16'sd16384},
    '{ 16'sd16384,  16'sd16384}
  };
  localparam q15_t HID_B [HIDDEN_COUNT] = '{16'sd0, 16'sd0, 16'sd0};

  localparam q15_t OUT_W [OUTPUT_COUNT][HIDDEN_COUNT] = '{
    '{16'sd16384, 16'sd0,     16'sd0},
    '{16'sd0,     16'sd16384, 16'sd0}
  };
  localparam q15_t OUT_B [OUTPUT_COUNT] = '{16'sd0, 16'sd0};

endpackage

/* rtl/core/smq_lane.sv */
// One neuron lane: Q15 products (truncated toward zero), then bias add, ReLU, clamp.
// Two register stages. Depends on smq_pkg.
`timescale 1ns / 1ps

module smq_lane #(
  parameter int N_IN = 2
) (
  input  logic              clk,
  input  smq_pkg::lane_ctl_t ctl,
  input  smq_pkg::q15_t     x    [N_IN],
  input  smq_pkg::q15_t     w    [N_IN],
  input  smq_pkg::q15_t     bias,
  output smq_pkg::act_t     act
);
  import smq_pkg::*;

  localparam int PROD_W = 2 * Q15_W;
  localparam int SHR_W  = PROD_W - FRACTION_BITS;   // shifted magnitude
  localparam int TERM_W = SHR_W + 1;                // signed term
  localparam int SUM_W  = TERM_W + $clog2(N_IN + 1);

  logic signed [PROD_W-1:0] prod_full [N_IN];
  logic        [PROD_W-1:0] prod_mag  [N_IN];
  logic        [SHR_W-1:0]  prod_shr  [N_IN];
  logic signed [TERM_W-1:0] term_nxt  [N_IN];
  logic signed [TERM_W-1:0] term_r    [N_IN];
  logic signed [SUM_W-1:0]  sum;
  act_t                     act_nxt;
  act_t                     act_r;

  // sign-magnitude scaling: shift |w*x| then restore the sign
  always_comb begin
    for (int i = 0; i < N_IN; i++) begin
      prod_full[i] = x[i] * w[i];
      prod_mag[i]  = prod_full[i][PROD_W-1] ? PROD_W'(-prod_full[i]) : prod_full[i];
      prod_shr[i]  = prod_mag[i][PROD_W-1:FRACTION_BITS];
      term_nxt[i]  = prod_full[i][PROD_W-1] ? -$signed({1'b0, prod_shr[i]})
                                            :  $signed({1'b0, prod_shr[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      for (int i = 0; i < N_IN; i++) term_r[i] <= term_nxt[i];
    end
  end

  always_comb begin
    sum = SUM_W'(bias);
    for (int i = 0; i < N_IN; i++) sum = sum + SUM_W'(term_r[i]);
    if (sum < 0) begin
      act_nxt = '0;
    end else if (sum > SUM_W'(ACT_MAX)) begin
      act_nxt = '1;
    end else begin
      act_nxt = sum[ACT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc_en) act_r <= act_nxt;
  end

  assign act = act_r;

endmodule

/* rtl/core/smq_argmax.sv */
// Merge stage: picks the largest output score (lower index on ties) and
// registers the scores with it. Depends on smq_pkg.
`timescale 1ns / 1ps

module smq_argmax (
  input  logic           clk,
  input  logic           en,
  input  smq_pkg::act_t  score_in  [smq_pkg::OUTPUT_COUNT],
  output smq_pkg::act_t  score_out [smq_pkg::OUTPUT_COUNT],
  output smq_pkg::class_t best
);
  import smq_pkg::*;

  class_t best_nxt;
  class_t best_r;
  act_t   score_r [OUTPUT_COUNT];

  // strict compare keeps the lower index on a tie
  always_comb begin
    best_nxt = '0;
    for (int k = 1; k < OUTPUT_COUNT; k++) begin
      if (score_in[k] > score_in[best_nxt]) best_nxt = CLASS_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      best_r <= best_nxt;
      for (int k = 0; k < OUTPUT_COUNT; k++) score_r[k] <= score_in[k];
    end
  end

  assign best      = best_r;
  assign score_out = score_r;

endmodule

/* rtl/core/small_mlp_q15_classifier_top.sv */
// Top level of the Q15 2-3-2 MLP classifier: lanes, argmax merge, pipeline control.
// Depends on smq_pkg, smq_lane and smq_argmax.
`timescale 1ns / 1ps

// Stateless 2-3-2 dense network on signed Q15 features. Each item (feature_a,
// feature_b) runs through a five-stage pipeline: three hidden lanes form their
// Q15 products (magnitude shifted right by 15, sign restored, so rounding is
// toward zero), then add bias, apply ReLU and clamp to 0..32767; two output
// lanes do the same over the hidden activations; the merge stage picks the
// larger score, index 0 on a tie. Throughput is one item per cycle while
// out_ready holds, since every stage is registered and takes a new item each
// cycle unless stalled. Each stage moves whenever its own slot is
// empty or the next stage moves, so bubbles close up and in_ready stays high
// while any slot is free, including while a finished item waits at the output.
// No configuration, no state beyond the pipeline; reset only clears the
// stage valid bits.

module small_mlp_q15_classifier_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    in_feature_a,
  input  logic signed [15:0]    in_feature_b,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [0:0]            out_class_index,
  output logic [14:0]           out_score_first,
  output logic [14:0]           out_score_second,
  output logic [15:0]           out_hidden_first,
  output logic [15:0]           out_hidden_second,
  output logic [15:0]           out_hidden_third
);
  import smq_pkg::*;

  // stage 0: hidden products, 1: hidden sums, 2: output products,
  // 3: output sums, 4: merge / output register
  localparam int STAGES = 5;

  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  logic [STAGES-1:0] en;

  q15_t      feat    [INPUT_COUNT];
  act_t      hid_act [HIDDEN_COUNT];
  q15_t      hid_q   [HIDDEN_COUNT];
  act_t      out_act [OUTPUT_COUNT];
  act_t      score   [OUTPUT_COUNT];
  class_t    best;
  lane_ctl_t hid_ctl;
  lane_ctl_t out_ctl;

  // hidden activations ride alongside the output layer
  act_t hid_s2_r [HIDDEN_COUNT];
  act_t hid_s3_r [HIDDEN_COUNT];
  act_t hid_s4_r [HIDDEN_COUNT];

  // per-stage enables, back from the output
  always_comb begin
    en[STAGES-1] = !vld_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) en[k] = !vld_r[k] || en[k+1];
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) vld_nxt[0] = in_valid;
    for (int k = 1; k < STAGES; k++) begin
      if (en[k]) vld_nxt[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[STAGES-1];

  assign feat[0] = in_feature_a;
  assign feat[1] = in_feature_b;

  assign hid_ctl = '{mul_en: en[0], acc_en: en[1]};
  assign out_ctl = '{mul_en: en[2], acc_en: en[3]};

  // hidden layer lanes
  for (genvar j = 0; j < HIDDEN_COUNT; j++) begin : g_hid
    smq_lane #(
      .N_IN (INPUT_COUNT)
    ) u_lane (
      .clk  (clk),
      .ctl  (hid_ctl),
      .x    (feat),
      .w    (HID_W[j]),
      .bias (HID_B[j]),
      .act  (hid_act[j])
    );
    assign hid_q[j] = $signed({1'b0, hid_act[j]});
  end

  // output layer lanes
  for (genvar j = 0; j < OUTPUT_COUNT; j++) begin : g_out
    smq_lane #(
      .N_IN (HIDDEN_COUNT)
    ) u_lane (
      .clk  (clk),
      .ctl  (out_ctl),
      .x    (hid_q),
      .w    (OUT_W[j]),
      .bias (OUT_B[j]),
      .act  (out_act[j])
    );
  end

  smq_argmax u_merge (
    .clk       (clk),
    .en        (en[4]),
    .score_in  (out_act),
    .score_out (score),
    .best      (best)
  );

  always_ff @(posedge clk) begin
    if (en[2]) hid_s2_r <= hid_act;
    if (en[3]) hid_s3_r <= hid_s2_r;
    if (en[4]) hid_s4_r <= hid_s3_r;
  end

  assign out_class_index   = best;
  assign out_score_first   = score[0];
  assign out_score_second  = score[1];
  assign out_hidden_first  = {1'b0, hid_s4_r[0]};
  assign out_hidden_second = {1'b0, hid_s4_r[1]};
  assign out_hidden_third  = {1'b0, hid_s4_r[2]};

  // an empty output slot always lets the pipeline take an item
  a_ready_when_out_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output slot");

  // a full, stalled pipeline must refuse new items
  a_full_stall_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r && !out_ready) |-> !in_ready)
    else $error("item taken into full stalled pipeline");

  // class index agrees with the scores it leaves with
  a_argmax_consistent : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_class_index == (out_score_second > out_score_first)))
    else $error("class index disagrees with scores");

  // clamped hidden activations never reach the top bit
  a_hidden_clamped : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hidden_first[15] || out_hidden_second[15] || out_hidden_third[15]))
    else $error("hidden activation above clamp");

endmodule

/* tb/smq_result_checker.sv */
// Checker for the Q15 2-3-2 MLP classifier: predicts each accepted item and
// compares results in order. Depends on nothing but the channel signals.
`timescale 1ns / 1ps

module smq_result_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic signed [15:0] in_feature_a,
  input  logic signed [15:0] in_feature_b,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [0:0]        out_class_index,
  input  logic [14:0]       out_score_first,
  input  logic [14:0]       out_score_second,
  input  logic [15:0]       out_hidden_first,
  input  logic [15:0]       out_hidden_second,
  input  logic [15:0]       out_hidden_third,
  output int unsigned       mismatch_count,
  output int unsigned       pending_count
);

  localparam int      Q_SHIFT  = 15;
  localparam longint  ACT_CLIP = 32767;

  localparam longint HIDDEN_WEIGHT [3][2] = '{
    '{ 16384, -16384},
    '{-16384,  16384},
    '{ 16384,  16384}
  };
  localparam longint HIDDEN_BIAS [3] = '{0, 0, 0};
  localparam longint SCORE_WEIGHT [2][3] = '{
    '{16384, 0,     0},
    '{0,     16384, 0}
  };
  localparam longint SCORE_BIAS [2] = '{0, 0};

  typedef struct packed {
    logic [0:0]  class_index;
    logic [14:0] score_first;
    logic [14:0] score_second;
    logic [15:0] hidden_first;
    logic [15:0] hidden_second;
    logic [15:0] hidden_third;
  } verdict_t;

  verdict_t expected_verdicts [$];

  // Q15 product, truncated toward zero on the magnitude
  function automatic longint q15_product(longint w, longint v);
    longint p;
    p = w * v;
    if (p < 0) return -((-p) >> Q_SHIFT);
    return p >> Q_SHIFT;
  endfunction

  function automatic longint relu_clip(longint v);
    if (v < 0) return 0;
    if (v > ACT_CLIP) return ACT_CLIP;
    return v;
  endfunction

  function automatic verdict_t classify_features(logic signed [15:0] a,
                                                 logic signed [15:0] b);
    longint   x [2];
    longint   h [3];
    longint   y [2];
    longint   acc;
    verdict_t r;
    x[0] = a;
    x[1] = b;
    for (int j = 0; j < 3; j++) begin
      acc = HIDDEN_BIAS[j];
      for (int i = 0; i < 2; i++) acc += q15_product(HIDDEN_WEIGHT[j][i], x[i]);
      h[j] = relu_clip(acc);
    end
    for (int j = 0; j < 2; j++) begin
      acc = SCORE_BIAS[j];
      for (int i = 0; i < 3; i++) acc += q15_product(SCORE_WEIGHT[j][i], h[i]);
      y[j] = relu_clip(acc);
    end
    r.class_index   = (y[1] > y[0]) ? 1'b1 : 1'b0;
    r.score_first   = y[0][14:0];
    r.score_second  = y[1][14:0];
    r.hidden_first  = h[0][15:0];
    r.hidden_second = h[1][15:0];
    r.hidden_third  = h[2][15:0];
    return r;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    verdict_t exp_r;
    if (rst_n) begin
      // retire first: a result never belongs to the item taken on the same edge
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result with no item outstanding");
          mismatch_count++;
        end else begin
          exp_r = expected_verdicts.pop_front();
          check_field("class_index",   exp_r.class_index,   out_class_index);
          check_field("score_first",   exp_r.score_first,   out_score_first);
          check_field("score_second",  exp_r.score_second,  out_score_second);
          check_field("hidden_first",  exp_r.hidden_first,  out_hidden_first);
          check_field("hidden_second", exp_r.hidden_second, out_hidden_second);
          check_field("hidden_third",  exp_r.hidden_third,  out_hidden_third);
        end
      end
      if (in_valid && in_ready)
        expected_verdicts.push_back(classify_features(in_feature_a, in_feature_b));
      pending_count = expected_verdicts.size();
    end else begin
      expected_verdicts.delete();
      mismatch_count = 0;
      pending_count  = 0;
    end
  end

endmodule

/* tb/tb_small_mlp_q15_classifier_top.sv */
// Testbench top for the Q15 2-3-2 MLP classifier: clock, reset, stimulus and verdict.
// Depends on small_mlp_q15_classifier_top and smq_result_checker.
`timescale 1ns / 1ps

module tb_small_mlp_q15_classifier_top;

  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 200000;  // far beyond the slowest legal run
  localparam int HOLD_CYCLES  = 120;     // long enough to fill all five stages
  localparam int DRAIN_CYCLES = 12;      // pipeline is 5 deep
  localparam int IDLE_PCT     = 29;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic signed [15:0] in_feature_a = '0;
  logic signed [15:0] in_feature_b = '0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [0:0]        out_class_index;
  logic [14:0]       out_score_first;
  logic [14:0]       out_score_second;
  logic [15:0]       out_hidden_first;
  logic [15:0]       out_hidden_second;
  logic [15:0]       out_hidden_third;

  int unsigned mismatch_count;
  int unsigned pending_count;

  // traffic shaping, written only by the stimulus process
  bit sender_gaps   = 1'b1;
  bit sink_gaps     = 1'b1;
  int hold_requests = 0;

  int unsigned cycle_count = 0;

  always #2 clk = ~clk;

  small_mlp_q15_classifier_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_feature_a      (in_feature_a),
    .in_feature_b      (in_feature_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_class_index   (out_class_index),
    .out_score_first   (out_score_first),
    .out_score_second  (out_score_second),
    .out_hidden_first  (out_hidden_first),
    .out_hidden_second (out_hidden_second),
    .out_hidden_third  (out_hidden_third)
  );

  smq_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_feature_a      (in_feature_a),
    .in_feature_b      (in_feature_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_class_index   (out_class_index),
    .out_score_first   (out_score_first),
    .out_score_second  (out_score_second),
    .out_hidden_first  (out_hidden_first),
    .out_hidden_second (out_hidden_second),
    .out_hidden_third  (out_hidden_third),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count)
  );

  // Watchdog: any hang ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_small_mlp_q15_classifier_top: done, errors");
      $finish;
    end
  end

  // Result side. A bumped hold_requests starts a long hold-off counted here,
  // while the sender keeps pushing: the five stages fill and in_ready drops.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (sink_gaps) begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one item; called and returning at a falling edge. Valid stays high
  // with a steady payload until the handshake lands on a rising edge.
  task automatic offer_item(input logic signed [15:0] a, input logic signed [15:0] b);
    if (sender_gaps) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_feature_a <= a;
    in_feature_b <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Random item shapes: full-range noise, values near zero where the
  // toward-zero truncation and tied scores show up, near-equal pairs, and
  // pairs pinned to the range limits.
  task automatic offer_random_item();
    logic signed [15:0] a;
    logic signed [15:0] b;
    a = 16'($urandom);
    b = 16'($urandom);
    case ($urandom_range(3))
      0: ;
      1: begin
        a = 16'($signed($urandom_range(16)) - 8);
        b = 16'($signed($urandom_range(16)) - 8);
      end
      2: b = a + 16'($signed($urandom_range(6)) - 3);
      default: begin
        if ($urandom_range(1)) a = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        else                   b = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      end
    endcase
    offer_item(a, b);
  endtask

  // Directed corners: range limits on both features, most negative input,
  // zero and unit values, odd values where truncation toward zero matters,
  // and pairs that tie the two scores (class 0 must win).
  localparam logic signed [15:0] DIR_A [22] = '{
    -16'sd32768, -16'sd32768,  16'sd32767,  16'sd32767,  16'sd0,
    -16'sd1,      16'sd1,     -16'sd1,      16'sd1,     -16'sd32768,
     16'sd0,      16'sd32767,  16'sd0,      16'sd3,     -16'sd3,
     16'sd100,   -16'sd100,    16'sd12345, -16'sd5,      16'sd1234,
     16'sd21845, -16'sd21846
  };
  localparam logic signed [15:0] DIR_B [22] = '{
    -16'sd32768,  16'sd32767, -16'sd32768,  16'sd32767,  16'sd0,
    -16'sd1,      16'sd1,      16'sd1,     -16'sd1,      16'sd0,
    -16'sd32768,  16'sd0,      16'sd32767,  16'sd2,     -16'sd2,
    -16'sd100,    16'sd100,   -16'sd23456,  16'sd4,      16'sd1234,
     16'sd10922, -16'sd10923
  };

  initial begin
    // reset held low from the start, released on a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIR_A[i]) offer_item(DIR_A[i], DIR_B[i]);

    // first random stretch with idling on both sides
    for (int n = 0; n < RANDOM_ITEMS / 3; n++) offer_random_item();

    // back-pressure: sink stalls long, source streams without gaps
    sender_gaps = 1'b0;
    hold_requests++;
    for (int n = 0; n < 40; n++) offer_random_item();

    // full-rate stretch with no idling anywhere
    sink_gaps = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS / 3; n++) offer_random_item();

    // back to random idling for the rest
    sender_gaps = 1'b1;
    sink_gaps   = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3) - 40; n++)
      offer_random_item();
    in_valid <= 1'b0;

    // drain, then keep watching to catch stray results
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("tb_small_mlp_q15_classifier_top: done, clean");
    else
      $display("tb_small_mlp_q15_classifier_top: done, errors");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/smq_pkg.sv
rtl/core/smq_lane.sv
rtl/core/smq_argmax.sv
rtl/core/small_mlp_q15_classifier_top.sv
tb/smq_result_checker.sv
tb/tb_small_mlp_q15_classifier_top.sv
